FILE: rtl/rbht_pkg.sv
// Shared constants, types and control bundles for the resizing bucket hash table.
package rbht_pkg;

	localparam int MAX_BUCKETS = 64;
	localparam int SLOTS       = 8;
	localparam int BKT_W       = $clog2(MAX_BUCKETS);
	localparam int SLOT_W      = $clog2(SLOTS);
	localparam int ADDR_W      = BKT_W + SLOT_W;
	localparam int DEPTH       = MAX_BUCKETS * SLOTS;
	localparam int FILL_W      = SLOT_W + 1;
	localparam int BT_W        = BKT_W + 1;
	localparam int CNT_W       = ADDR_W + 1;
	localparam int KEY_W       = 63;
	localparam int VAL_W       = 32;
	localparam int MOD_BITS    = 4;
	localparam int MOD_CYC     = (KEY_W + 1) / MOD_BITS;
	localparam int MOD_CNT_W   = $clog2(MOD_CYC);

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_GET    = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2,
		ST_LOST = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		WD_INPUT   = 2'd0,
		WD_STORE   = 2'd1,
		WD_SCRATCH = 2'd2
	} wdata_sel_t;

	typedef enum logic [4:0] {
		S_IDLE, S_DISPATCH, S_MOD_WAIT, S_FILL_RD, S_FILL_CHK, S_INS,
		S_GET_RD, S_GET_CMP, S_RM_RD, S_RM_CMP, S_RM_END,
		S_RB_INIT, S_RB_FRD, S_RB_FCHK, S_RB_ERD, S_RB_ECP, S_RB_SWAP,
		S_RB_SRD, S_RB_SMOD, S_RB_SWAIT, S_RB_SFRD, S_RB_SFCHK, S_RB_SINS,
		S_RB_END, S_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]       op;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [VAL_W-1:0] found_value;
		logic [BT_W-1:0]  bucket_total;
	} out_item_t;

	typedef struct packed {
		logic       latch;
		logic       mod_start;
		logic       mod_src_scr;
		logic       set_b;
		logic       fa_sel_i;
		logic       cap_fill;
		logic       clr_j;
		logic       inc_j;
		logic       st_ra_i;
		logic       st_we;
		logic       st_wsel_w;
		wdata_sel_t st_dsel;
		logic       fill_we;
		logic       fill_wsel_w;
		logic       inc_items;
		logic       inc_w;
		logic       inc_rm;
		logic       rm_commit;
		logic       set_status;
		status_t    status_code;
		logic       set_found;
		logic       clr_i_n;
		logic       inc_i;
		logic       scr_we;
		logic       swap;
		logic       inc_k;
		logic       inc_lost;
		logic       rb_commit;
		logic       set_rebuilt;
		logic       set_rb_mode;
		logic       rb_grow_val;
		logic       finish;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic mod_done;
		logic grow_need;
		logic grow_ok;
		logic rebuilt;
		logic fill_full;
		logic j_end;
		logic key_match;
		logic i_end;
		logic k_end;
		logic w_zero;
		logic rm_zero;
		logic bt_gt1;
		logic lost_nz;
		logic rb_grow;
	} flags_t;

endpackage

FILE: rtl/rbht_mod.sv
// Iterative remainder unit: key modulo bucket count, a few bits per cycle.
module rbht_mod (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rbht_pkg::KEY_W-1:0] dividend,
	input  logic [rbht_pkg::BT_W-1:0]  divisor,
	output logic                       done,
	output logic [rbht_pkg::BKT_W-1:0] rem
);
	import rbht_pkg::*;

	logic [KEY_W:0]     shift_q;
	logic [BKT_W-1:0]   rem_q;
	logic [MOD_CNT_W-1:0] cnt_q;
	logic               run_q;
	logic               done_q;
	logic [BKT_W-1:0]   rem_nxt;

	// Restoring steps: the partial remainder stays below the divisor.
	always_comb begin
		logic [BT_W-1:0]  x;
		logic [BKT_W-1:0] t;
		t = rem_q;
		x = '0;
		for (int s = 0; s < MOD_BITS; s++) begin
			x = {t, shift_q[KEY_W - s]};
			if (x >= divisor) begin
				x = x - divisor;
			end
			t = x[BKT_W-1:0];
		end
		rem_nxt = t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == MOD_CNT_W'(MOD_CYC - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= {1'b0, dividend};
			rem_q   <= '0;
		end else if (run_q) begin
			shift_q <= shift_q << MOD_BITS;
			rem_q   <= rem_nxt;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

FILE: rtl/rbht_dp.sv
// Datapath: input latch, stores, fill counts, counters and result register.
module rbht_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  rbht_pkg::in_item_t  item,
	input  rbht_pkg::cmd_t      cmd,
	output rbht_pkg::flags_t    flags,
	output rbht_pkg::out_item_t result,
	output logic                done
);
	import rbht_pkg::*;

	logic [KEY_W-1:0]       key_mem [DEPTH];
	logic [VAL_W-1:0]       val_mem [DEPTH];
	logic [KEY_W+VAL_W-1:0] scr_mem [DEPTH];
	logic [FILL_W-1:0]      fill_mem [MAX_BUCKETS];
	logic [MAX_BUCKETS-1:0] fill_vld_q;

	logic [1:0]       op_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;
	logic [BT_W-1:0]  bt_q;
	logic [CNT_W-1:0] items_q;
	logic [BKT_W-1:0] b_q;
	logic [FILL_W-1:0] fill_rd_q, fill_cur_q;
	logic             fill_vld_rd_q;
	logic [FILL_W-1:0] j_q, w_q, rm_q;
	logic [BT_W-1:0]  i_q;
	logic [CNT_W-1:0] n_q, k_q, lost_q;
	status_t          status_q;
	logic [VAL_W-1:0] found_q;
	logic             rebuilt_q, rb_grow_q;
	logic [KEY_W-1:0] st_key_q;
	logic [VAL_W-1:0] st_val_q;
	logic [KEY_W+VAL_W-1:0] scr_q;
	out_item_t        res_q;
	logic             done_q;

	logic [BKT_W-1:0]  fill_addr;
	logic [FILL_W-1:0] fill_eff;
	logic [ADDR_W-1:0] st_raddr, st_waddr;
	logic [KEY_W-1:0]  st_wkey, mod_key;
	logic [VAL_W-1:0]  st_wval;
	logic [FILL_W-1:0] fill_wdata;
	logic              mod_done;
	logic [BKT_W-1:0]  mod_rem;

	rbht_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.mod_start),
		.dividend (mod_key),
		.divisor  (bt_q),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	assign mod_key   = cmd.mod_src_scr ? scr_q[KEY_W+VAL_W-1:VAL_W] : key_q;
	assign fill_addr = cmd.fa_sel_i ? i_q[BKT_W-1:0] : b_q;
	assign fill_eff  = fill_vld_rd_q ? fill_rd_q : '0;
	assign st_raddr  = cmd.st_ra_i ? {i_q[BKT_W-1:0], j_q[SLOT_W-1:0]}
	                               : {b_q, j_q[SLOT_W-1:0]};
	assign st_waddr  = cmd.st_wsel_w ? {b_q, w_q[SLOT_W-1:0]}
	                                 : {b_q, fill_cur_q[SLOT_W-1:0]};
	assign fill_wdata = cmd.fill_wsel_w ? w_q : fill_cur_q + 1'b1;

	always_comb begin
		case (cmd.st_dsel)
			WD_STORE: begin
				st_wkey = st_key_q;
				st_wval = st_val_q;
			end
			WD_SCRATCH: begin
				st_wkey = scr_q[KEY_W+VAL_W-1:VAL_W];
				st_wval = scr_q[VAL_W-1:0];
			end
			default: begin
				st_wkey = key_q;
				st_wval = val_q;
			end
		endcase
	end

	// Memories: one write and one registered read each per cycle.
	always_ff @(posedge clk) begin
		if (cmd.st_we) begin
			key_mem[st_waddr] <= st_wkey;
			val_mem[st_waddr] <= st_wval;
		end
		st_key_q <= key_mem[st_raddr];
		st_val_q <= val_mem[st_raddr];
		if (cmd.scr_we) begin
			scr_mem[n_q[ADDR_W-1:0]] <= {st_key_q, st_val_q};
		end
		scr_q <= scr_mem[k_q[ADDR_W-1:0]];
		if (cmd.fill_we) begin
			fill_mem[b_q] <= fill_wdata;
		end
		fill_rd_q <= fill_mem[fill_addr];
	end

	// An entry whose valid bit is clear reads as an empty bucket.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_vld_q    <= '0;
			fill_vld_rd_q <= 1'b0;
		end else begin
			fill_vld_rd_q <= fill_vld_q[fill_addr];
			if (cmd.swap) begin
				fill_vld_q <= '0;
			end else if (cmd.fill_we) begin
				fill_vld_q[b_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q  <= item.op;
			key_q <= item.key;
			val_q <= item.value;
		end
		if (cmd.set_b) begin
			b_q <= mod_rem;
		end
		if (cmd.cap_fill) begin
			fill_cur_q <= fill_eff;
		end
		if (cmd.set_found) begin
			found_q <= st_val_q;
		end else if (cmd.latch) begin
			found_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bt_q      <= BT_W'(1);
			items_q   <= '0;
			j_q       <= '0;
			w_q       <= '0;
			rm_q      <= '0;
			i_q       <= '0;
			n_q       <= '0;
			k_q       <= '0;
			lost_q    <= '0;
			status_q  <= ST_DONE;
			rebuilt_q <= 1'b0;
			rb_grow_q <= 1'b0;
			res_q     <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.latch) begin
				status_q  <= ST_DONE;
				rebuilt_q <= 1'b0;
			end
			if (cmd.set_status) begin
				status_q <= cmd.status_code;
			end
			if (cmd.set_rebuilt) begin
				rebuilt_q <= 1'b1;
			end
			if (cmd.set_rb_mode) begin
				rb_grow_q <= cmd.rb_grow_val;
			end
			if (cmd.clr_j) begin
				j_q  <= '0;
				w_q  <= '0;
				rm_q <= '0;
			end else begin
				if (cmd.inc_j) j_q <= j_q + 1'b1;
				if (cmd.inc_w) w_q <= w_q + 1'b1;
				if (cmd.inc_rm) rm_q <= rm_q + 1'b1;
			end
			if (cmd.clr_i_n) begin
				i_q <= '0;
				n_q <= '0;
			end else begin
				if (cmd.inc_i) i_q <= i_q + 1'b1;
				if (cmd.scr_we) n_q <= n_q + 1'b1;
			end
			if (cmd.swap) begin
				bt_q   <= rb_grow_q ? bt_q << 1 : bt_q - 1'b1;
				k_q    <= '0;
				lost_q <= '0;
			end else begin
				if (cmd.inc_k) k_q <= k_q + 1'b1;
				if (cmd.inc_lost) lost_q <= lost_q + 1'b1;
			end
			if (cmd.inc_items) begin
				items_q <= items_q + 1'b1;
			end else if (cmd.rm_commit) begin
				items_q <= (items_q >= CNT_W'(rm_q)) ? items_q - CNT_W'(rm_q) : '0;
			end else if (cmd.rb_commit) begin
				items_q <= n_q - lost_q;
			end
			if (cmd.finish) begin
				res_q.status       <= status_q;
				res_q.found_value  <= found_q;
				res_q.bucket_total <= bt_q;
				done_q             <= 1'b1;
			end
		end
	end

	always_comb begin
		flags.op        = op_t'(op_q);
		flags.mod_done  = mod_done;
		flags.grow_need = ({1'b0, fill_eff} + 1'b1 >= (FILL_W + 1)'(SLOTS)) ||
		                  (items_q >= (CNT_W'(bt_q) << SLOT_W));
		flags.grow_ok   = ({1'b0, bt_q} << 1) <= (BT_W + 1)'(MAX_BUCKETS);
		flags.rebuilt   = rebuilt_q;
		flags.fill_full = fill_cur_q >= FILL_W'(SLOTS);
		flags.j_end     = j_q >= fill_cur_q;
		flags.key_match = st_key_q == key_q;
		flags.i_end     = i_q >= bt_q;
		flags.k_end     = k_q >= n_q;
		flags.w_zero    = w_q == '0;
		flags.rm_zero   = rm_q == '0;
		flags.bt_gt1    = bt_q > BT_W'(1);
		flags.lost_nz   = lost_q != '0;
		flags.rb_grow   = rb_grow_q;
	end

	assign result = res_q;
	assign done   = done_q;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("result strobe held longer than one cycle");
	a_bt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(bt_q >= BT_W'(1)) && (bt_q <= BT_W'(MAX_BUCKETS)))
		else $error("bucket count out of range");
	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.cap_fill) |-> fill_cur_q <= FILL_W'(SLOTS))
		else $error("bucket fill above slot count");

endmodule

FILE: rtl/rbht_ctrl.sv
// Controller state machine sequencing lookups, inserts, removals and rehashes.
module rbht_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  rbht_pkg::flags_t flags,
	output rbht_pkg::cmd_t   cmd,
	output logic             busy
);
	import rbht_pkg::*;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_nxt = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (flags.op == OP_NOP) begin
					state_nxt = S_DONE;
				end else begin
					cmd.mod_start = 1'b1;
					state_nxt     = S_MOD_WAIT;
				end
			end
			S_MOD_WAIT: begin
				if (flags.mod_done) begin
					cmd.set_b = 1'b1;
					state_nxt = S_FILL_RD;
				end
			end
			S_FILL_RD: begin
				cmd.clr_j = 1'b1;
				state_nxt = S_FILL_CHK;
			end
			S_FILL_CHK: begin
				cmd.cap_fill = 1'b1;
				case (flags.op)
					OP_INSERT: begin
						if (!flags.rebuilt && flags.grow_need && flags.grow_ok) begin
							cmd.set_rb_mode = 1'b1;
							cmd.rb_grow_val = 1'b1;
							state_nxt       = S_RB_INIT;
						end else begin
							state_nxt = S_INS;
						end
					end
					OP_REMOVE: state_nxt = S_RM_RD;
					OP_GET:    state_nxt = S_GET_RD;
					default:   state_nxt = S_DONE;
				endcase
			end
			S_INS: begin
				if (flags.fill_full) begin
					cmd.set_status  = 1'b1;
					cmd.status_code = ST_FULL;
				end else begin
					cmd.st_we     = 1'b1;
					cmd.st_dsel   = WD_INPUT;
					cmd.fill_we   = 1'b1;
					cmd.inc_items = 1'b1;
				end
				state_nxt = S_DONE;
			end
			S_GET_RD: begin
				if (flags.j_end) begin
					cmd.set_status  = 1'b1;
					cmd.status_code = ST_MISS;
					state_nxt       = S_DONE;
				end else begin
					state_nxt = S_GET_CMP;
				end
			end
			S_GET_CMP: begin
				if (flags.key_match) begin
					cmd.set_found = 1'b1;
					state_nxt     = S_DONE;
				end else begin
					cmd.inc_j = 1'b1;
					state_nxt = S_GET_RD;
				end
			end
			S_RM_RD: begin
				state_nxt = flags.j_end ? S_RM_END : S_RM_CMP;
			end
			S_RM_CMP: begin
				// Survivors are packed down toward the start of the bucket.
				if (flags.key_match) begin
					cmd.inc_rm = 1'b1;
				end else begin
					cmd.st_we     = 1'b1;
					cmd.st_wsel_w = 1'b1;
					cmd.st_dsel   = WD_STORE;
					cmd.inc_w     = 1'b1;
				end
				cmd.inc_j = 1'b1;
				state_nxt = S_RM_RD;
			end
			S_RM_END: begin
				cmd.fill_we     = 1'b1;
				cmd.fill_wsel_w = 1'b1;
				cmd.rm_commit   = 1'b1;
				if (flags.rm_zero) begin
					cmd.set_status  = 1'b1;
					cmd.status_code = ST_MISS;
				end
				if (flags.w_zero && flags.bt_gt1) begin
					cmd.set_rb_mode = 1'b1;
					cmd.rb_grow_val = 1'b0;
					state_nxt       = S_RB_INIT;
				end else begin
					state_nxt = S_DONE;
				end
			end
			S_RB_INIT: begin
				cmd.clr_i_n = 1'b1;
				state_nxt   = S_RB_FRD;
			end
			S_RB_FRD: begin
				cmd.fa_sel_i = 1'b1;
				state_nxt    = flags.i_end ? S_RB_SWAP : S_RB_FCHK;
			end
			S_RB_FCHK: begin
				cmd.fa_sel_i = 1'b1;
				cmd.cap_fill = 1'b1;
				cmd.clr_j    = 1'b1;
				state_nxt    = S_RB_ERD;
			end
			S_RB_ERD: begin
				cmd.st_ra_i = 1'b1;
				if (flags.j_end) begin
					cmd.inc_i = 1'b1;
					state_nxt = S_RB_FRD;
				end else begin
					state_nxt = S_RB_ECP;
				end
			end
			S_RB_ECP: begin
				cmd.scr_we = 1'b1;
				cmd.inc_j  = 1'b1;
				state_nxt  = S_RB_ERD;
			end
			S_RB_SWAP: begin
				cmd.swap  = 1'b1;
				state_nxt = S_RB_SRD;
			end
			S_RB_SRD: begin
				state_nxt = flags.k_end ? S_RB_END : S_RB_SMOD;
			end
			S_RB_SMOD: begin
				cmd.mod_start   = 1'b1;
				cmd.mod_src_scr = 1'b1;
				state_nxt       = S_RB_SWAIT;
			end
			S_RB_SWAIT: begin
				if (flags.mod_done) begin
					cmd.set_b = 1'b1;
					state_nxt = S_RB_SFRD;
				end
			end
			S_RB_SFRD: begin
				state_nxt = S_RB_SFCHK;
			end
			S_RB_SFCHK: begin
				cmd.cap_fill = 1'b1;
				state_nxt    = S_RB_SINS;
			end
			S_RB_SINS: begin
				if (flags.fill_full) begin
					cmd.inc_lost = 1'b1;
				end else begin
					cmd.st_we   = 1'b1;
					cmd.st_dsel = WD_SCRATCH;
					cmd.fill_we = 1'b1;
				end
				cmd.inc_k = 1'b1;
				state_nxt = S_RB_SRD;
			end
			S_RB_END: begin
				cmd.rb_commit = 1'b1;
				if (flags.rb_grow) begin
					// After growing, the insert looks up its new bucket again.
					cmd.set_rebuilt = 1'b1;
					cmd.mod_start   = 1'b1;
					state_nxt       = S_MOD_WAIT;
				end else begin
					if (flags.lost_nz) begin
						cmd.set_status  = 1'b1;
						cmd.status_code = ST_LOST;
					end
					state_nxt = S_DONE;
				end
			end
			S_DONE: begin
				cmd.finish = 1'b1;
				state_nxt  = S_IDLE;
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	assign busy = state_q != S_IDLE;

endmodule

FILE: rtl/resizing_bucket_hash_table.sv
// Top level of the resizing bucket hash table.
// Usage: present an operation on item (op, key, value) and raise start; the
// transfer takes place at a clock edge where start is high and busy is low.
// busy then stays high until the operation has finished. Exactly one result
// transfer follows each operation: done is high for one cycle with status,
// found_value and bucket_total on result. The receiver cannot stall, so it
// must take the result in that cycle.
// Timing: every key lookup runs the remainder unit, four quotient bits per
// cycle over the 63-bit key padded to 64 bits. A get and a remove take
// longer with each slot examined. A resize walks the whole table through
// the single store ports: it first gathers every bucket's entries, then
// rehashes each entry, each rehashed entry paying one remainder pass.
// The next operation can be taken in the cycle in which done is high.
// Reset: one bucket, no items; bucket fills clear at once through per-bucket
// valid bits, so no clearing pass is needed and the block is ready at once.
module resizing_bucket_hash_table (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  rbht_pkg::in_item_t  item,
	output logic                done,
	output rbht_pkg::out_item_t result
);
	import rbht_pkg::*;

	cmd_t   cmd;
	flags_t flags;

	rbht_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.flags  (flags),
		.cmd    (cmd),
		.busy   (busy)
	);

	rbht_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.flags  (flags),
		.result (result),
		.done   (done)
	);

endmodule

FILE: tb/tb_resizing_bucket_hash_table_chk.sv
// Checker that predicts and compares every result of the resizing bucket hash table.
`timescale 1ns / 100ps
module tb_resizing_bucket_hash_table_chk (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  rbht_pkg::in_item_t  item,
	input  logic                done,
	input  rbht_pkg::out_item_t result,
	output int                  errors,
	output int                  pending
);
	import rbht_pkg::*;

	logic [KEY_W-1:0] key_mem [DEPTH];
	logic [VAL_W-1:0] val_mem [DEPTH];
	logic [KEY_W-1:0] gather_key [DEPTH];
	logic [VAL_W-1:0] gather_val [DEPTH];
	int               bucket_fill [MAX_BUCKETS];
	int               buckets;
	int               entries;
	out_item_t        expected_results [$];

	function automatic int home_bucket(logic [KEY_W-1:0] k);
		return int'(64'(k) % 64'(buckets));
	endfunction

	// Rehashes every entry into new_buckets buckets and returns the number dropped.
	function automatic int rehash_table(int new_buckets);
		int n;
		int dropped;
		int b;
		n = 0;
		dropped = 0;
		for (int i = 0; i < buckets; i++) begin
			for (int j = 0; j < bucket_fill[i]; j++) begin
				gather_key[n] = key_mem[i*SLOTS+j];
				gather_val[n] = val_mem[i*SLOTS+j];
				n++;
			end
		end
		buckets = new_buckets;
		for (int i = 0; i < MAX_BUCKETS; i++) bucket_fill[i] = 0;
		for (int i = 0; i < n; i++) begin
			b = home_bucket(gather_key[i]);
			if (bucket_fill[b] < SLOTS) begin
				key_mem[b*SLOTS+bucket_fill[b]] = gather_key[i];
				val_mem[b*SLOTS+bucket_fill[b]] = gather_val[i];
				bucket_fill[b]++;
			end else begin
				dropped++;
			end
		end
		entries = n - dropped;
		return dropped;
	endfunction

	function automatic out_item_t apply_table_op(in_item_t it);
		out_item_t r;
		int b;
		int w;
		int removed;
		r = '0;
		r.status = ST_DONE;
		case (op_t'(it.op))
			OP_INSERT: begin
				b = home_bucket(it.key);
				if (bucket_fill[b] + 1 >= SLOTS || entries / buckets >= SLOTS) begin
					if (buckets * 2 <= MAX_BUCKETS) begin
						void'(rehash_table(buckets * 2));
						b = home_bucket(it.key);
					end
				end
				if (bucket_fill[b] < SLOTS) begin
					key_mem[b*SLOTS+bucket_fill[b]] = it.key;
					val_mem[b*SLOTS+bucket_fill[b]] = it.value;
					bucket_fill[b]++;
					entries++;
				end else begin
					r.status = ST_FULL;
				end
			end
			OP_REMOVE: begin
				b = home_bucket(it.key);
				w = 0;
				removed = 0;
				for (int j = 0; j < bucket_fill[b]; j++) begin
					if (key_mem[b*SLOTS+j] == it.key) begin
						removed++;
					end else begin
						key_mem[b*SLOTS+w] = key_mem[b*SLOTS+j];
						val_mem[b*SLOTS+w] = val_mem[b*SLOTS+j];
						w++;
					end
				end
				bucket_fill[b] = w;
				entries = (entries >= removed) ? entries - removed : 0;
				if (removed == 0) r.status = ST_MISS;
				if (w == 0 && buckets > 1) begin
					if (rehash_table(buckets - 1) != 0) r.status = ST_LOST;
				end
			end
			OP_GET: begin
				r.status = ST_MISS;
				b = home_bucket(it.key);
				for (int j = 0; j < bucket_fill[b]; j++) begin
					if (key_mem[b*SLOTS+j] == it.key) begin
						r.found_value = val_mem[b*SLOTS+j];
						r.status = ST_DONE;
						break;
					end
				end
			end
			default: ;
		endcase
		r.bucket_total = BT_W'(buckets);
		return r;
	endfunction

	assign pending = expected_results.size();

	always @(posedge clk) begin
		out_item_t want;
		int bad;
		bad = 0;
		if (!arst_n) begin
			buckets = 1;
			entries = 0;
			for (int i = 0; i < MAX_BUCKETS; i++) bucket_fill[i] = 0;
			expected_results.delete();
			errors <= 0;
		end else begin
			// Compare first: a new operation may be taken in the cycle of the result.
			if (done) begin
				if (expected_results.size() == 0) begin
					$error("result transfer with no operation outstanding");
					bad++;
				end else begin
					want = expected_results.pop_front();
					if (result.status !== want.status) begin
						$error("status expected %0d actual %0d", want.status, result.status);
						bad++;
					end
					if (result.found_value !== want.found_value) begin
						$error("found_value expected %0h actual %0h",
							want.found_value, result.found_value);
						bad++;
					end
					if (result.bucket_total !== want.bucket_total) begin
						$error("bucket_total expected %0d actual %0d",
							want.bucket_total, result.bucket_total);
						bad++;
					end
				end
			end
			if (start && !busy) expected_results.push_back(apply_table_op(item));
			errors <= errors + bad;
		end
	end

endmodule

FILE: tb/tb_resizing_bucket_hash_table.sv
// Top of the resizing bucket hash table testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_resizing_bucket_hash_table;
	import rbht_pkg::*;

	localparam int IDLE_LIMIT = 200000;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	in_item_t  item;
	logic      done;
	out_item_t result;
	int        errors;
	int        pending;
	int        idle_cycles;

	resizing_bucket_hash_table uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.item(item), .done(done), .result(result)
	);

	tb_resizing_bucket_hash_table_chk chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.item(item), .done(done), .result(result),
		.errors(errors), .pending(pending)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
	end

	always @(posedge clk) begin
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("resizing_bucket_hash_table: mismatch");
			$finish;
		end
	end

	// Holds start for one transfer; returns at the falling edge after it.
	task automatic send_op(op_t op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
		item.op    = op;
		item.key   = k;
		item.value = v;
		start      = 1'b1;
		while (busy) @(negedge clk);
		@(negedge clk);
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		int sel;
		sel = $urandom_range(99);
		if (sel < 70) return KEY_W'($urandom_range(31));
		if (sel < 85) return KEY_W'($urandom_range(7)) * 64;
		return KEY_W'({$urandom, $urandom} >> 1);
	endfunction

	function automatic op_t pick_op();
		int sel;
		sel = $urandom_range(99);
		if (sel < 40) return OP_INSERT;
		if (sel < 70) return OP_REMOVE;
		if (sel < 95) return OP_GET;
		return OP_NOP;
	endfunction

	initial begin
		int burst;
		int sent;
		start = 1'b0;
		item  = '0;
		arst_n = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Repeated inserts of one key fill its bucket; from SLOTS-1 entries on, each
		// insert grows the table, and once the bucket is full the insert is dropped.
		for (int i = 0; i < 10; i++) send_op(OP_INSERT, '0, VAL_W'(i + 1));
		send_op(OP_GET, '0, '0);
		send_op(OP_GET, '1, '0);
		send_op(OP_INSERT, '1, '1);
		send_op(OP_GET, '1, '0);
		send_op(OP_REMOVE, '0, '1);
		send_op(OP_REMOVE, KEY_W'(5), '0);
		send_op(OP_NOP, '1, '1);
		send_op(OP_GET, KEY_W'(5), '0);
		send_op(OP_REMOVE, '1, '0);
		start = 1'b0;

		sent = 0;
		while (sent < 1700) begin
			burst = $urandom_range(1, 20);
			for (int i = 0; i < burst; i++) begin
				send_op(pick_op(), pick_key(), $urandom);
				sent++;
			end
			start = 1'b0;
			if (sent % 300 < burst) begin
				while (pending != 0) @(negedge clk);
			end
			if ($urandom_range(3) != 0) repeat ($urandom_range(15)) @(negedge clk);
		end
		start = 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		if (errors == 0) begin
			$display("resizing_bucket_hash_table: match");
		end else begin
			$display("resizing_bucket_hash_table: mismatch");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/rbht_pkg.sv
rtl/rbht_mod.sv
rtl/rbht_dp.sv
rtl/rbht_ctrl.sv
rtl/resizing_bucket_hash_table.sv
tb/tb_resizing_bucket_hash_table_chk.sv
tb/tb_resizing_bucket_hash_table.sv
